### design/pgip_pkg.sv
// Shared widths, defaults and the set descriptor of the permutation gather block.
package pgip_pkg;

    localparam int VALUE_W        = 32;
    localparam int INDEX_W        = 6;
    localparam int IN_DATA_W      = 40;
    localparam int OUT_DATA_W     = 32;
    localparam int DEF_DEPTH      = 64;
    localparam int DEF_ELEM_WIDTH = 32;

    // One closed set as handed from the loader to the emitter.
    typedef struct packed {
        logic               bad;
        logic [INDEX_W-1:0] last_pos;
    } set_desc_t;

endpackage

### design/pgip_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module pgip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/pgip_front.sv
// Loader: writes incoming elements and indices into the current bank and checks the set.
module pgip_front import pgip_pkg::*; #(
    parameter int DEPTH      = DEF_DEPTH,
    parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [VALUE_W-1:0]         elem_value,
    input  logic [INDEX_W-1:0]         source_index,
    input  logic                       last_item,
    output logic                       wr_en,
    output logic [$clog2(DEPTH):0]     wr_addr,
    output logic [ELEM_WIDTH-1:0]      wr_value,
    output logic [$clog2(DEPTH)-1:0]   wr_index,
    input  logic                       q_full,
    output logic                       push,
    output set_desc_t                  push_desc
);

    localparam int AW = $clog2(DEPTH);

    logic [AW-1:0]      pos_reg, pos_next;
    logic               bank_reg, bank_next;
    logic               dup_reg, dup_next;
    logic [INDEX_W-1:0] max_reg, max_next;
    logic [DEPTH-1:0]   seen_reg, seen_next;

    logic               accept;
    logic               in_range;
    logic [AW-1:0]      idx_lo;
    logic               dup_now;
    logic [INDEX_W-1:0] max_now;
    logic               close;
    logic [AW:0]        set_len;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign in_range = ({1'b0, source_index} < (INDEX_W + 1)'(DEPTH));
    assign idx_lo   = source_index[AW-1:0];
    assign dup_now  = in_range && seen_reg[idx_lo];
    assign max_now  = (source_index > max_reg) ? source_index : max_reg;
    assign close    = last_item || (pos_reg == AW'(DEPTH - 1));
    assign set_len  = {1'b0, pos_reg} + (AW + 1)'(1);

    assign wr_en    = accept;
    assign wr_addr  = {bank_reg, pos_reg};
    assign wr_value = ELEM_WIDTH'(elem_value);
    assign wr_index = idx_lo;

    assign push              = accept && close;
    assign push_desc.bad     = dup_reg || dup_now ||
                               ((INDEX_W + 1)'(max_now) >= (INDEX_W + 1)'(set_len));
    assign push_desc.last_pos = INDEX_W'(pos_reg);

    always_comb
    begin
        pos_next  = pos_reg;
        bank_next = bank_reg;
        dup_next  = dup_reg;
        max_next  = max_reg;
        seen_next = seen_reg;
        if (accept)
        begin
            if (close)
            begin
                pos_next  = '0;
                bank_next = !bank_reg;
                dup_next  = 1'b0;
                max_next  = '0;
                seen_next = '0;
            end
            else
            begin
                pos_next = pos_reg + AW'(1);
                dup_next = dup_reg || dup_now;
                max_next = max_now;
                if (in_range)
                begin
                    seen_next[idx_lo] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            bank_reg <= 1'b0;
            dup_reg  <= 1'b0;
            max_reg  <= '0;
            seen_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            bank_reg <= bank_next;
            dup_reg  <= dup_next;
            max_reg  <= max_next;
            seen_reg <= seen_next;
        end
    end

endmodule

### design/pgip_queue.sv
// Two-entry queue of closed sets, one entry per store bank.
module pgip_queue import pgip_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  set_desc_t push_desc,
    output logic      full,
    input  logic      pop,
    output logic      valid,
    output set_desc_t head
);

    set_desc_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> !full)
        else $error("Set queue written while full.");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("Set queue read while empty.");

    a_pointers_match_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("Set queue pointers disagree with the fill count.");

endmodule

### design/pgip_back.sv
// Emitter: gathers each position's source element from the bank and drives the result stream.
module pgip_back import pgip_pkg::*; #(
    parameter int DEPTH      = DEF_DEPTH,
    parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  set_desc_t                  q_head,
    output logic                       pop,
    output logic                       idx_re,
    output logic [$clog2(DEPTH):0]     idx_raddr,
    input  logic [$clog2(DEPTH)-1:0]   idx_rdata,
    output logic                       val_re,
    output logic [$clog2(DEPTH):0]     val_raddr,
    input  logic [ELEM_WIDTH-1:0]      val_rdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tlast,
    output logic                       m_tuser
);

    localparam int AW = $clog2(DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_IDX  = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_ERR  = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic          bank_reg, bank_next;
    logic          at_last;

    assign at_last = (pos_reg == q_head.last_pos[AW-1:0]);

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        bank_next  = bank_reg;
        pop        = 1'b0;
        idx_re     = 1'b0;
        idx_raddr  = {bank_reg, pos_reg};
        val_re     = 1'b0;
        val_raddr  = {bank_reg, idx_rdata};
        m_tvalid   = 1'b0;
        m_tdata    = '0;
        m_tlast    = 1'b0;
        m_tuser    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_head.bad)
                    begin
                        state_next = ST_ERR;
                    end
                    else
                    begin
                        pos_next   = '0;
                        idx_re     = 1'b1;
                        idx_raddr  = {bank_reg, {AW{1'b0}}};
                        state_next = ST_IDX;
                    end
                end
            end
            ST_IDX:
            begin
                val_re     = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                m_tvalid = 1'b1;
                m_tdata  = OUT_DATA_W'(val_rdata);
                m_tlast  = at_last;
                if (m_tready)
                begin
                    if (at_last)
                    begin
                        pop        = 1'b1;
                        bank_next  = !bank_reg;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_reg + AW'(1);
                        idx_re     = 1'b1;
                        idx_raddr  = {bank_reg, pos_reg + AW'(1)};
                        state_next = ST_IDX;
                    end
                end
            end
            ST_ERR:
            begin
                m_tvalid = 1'b1;
                m_tlast  = 1'b1;
                m_tuser  = 1'b1;
                if (m_tready)
                begin
                    pop        = 1'b1;
                    bank_next  = !bank_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            bank_reg  <= bank_next;
        end
    end

    a_pop_needs_set: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("Emitter released a set that was never queued.");

    a_error_is_lone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
        else $error("Rejected set result is not a lone zero result.");

    a_emit_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_EMIT) |-> $past(state_reg == ST_IDX))
        else $error("Result shown before its element was read.");

endmodule

### design/permutation_gather_in_place.sv
// Top level of the in-place permutation gather block: loader, set queue, emitter and two banked stores.
//
// Channel   Direction  Handshake           Payload
// s_*       in         s_tvalid/s_tready   s_tdata: elem_value, source_index; s_tlast: last_item
// m_*       out        m_tvalid/m_tready   m_tdata: out_value; m_tlast: out_last; m_tuser: flag
//
// Elements load at one transaction per cycle, while s_tready is high, into one of two store banks.
// Each result needs an index read followed by an element read on the registered RAM ports,
// and the idle state issues the first index read of each set.
// A rejected set gives its single result in the cycle after it reaches the emitter.
// s_tready drops only while two closed sets wait for the emitter; m_tready stalls only the emitter.
// Reset is asynchronous and active low, and the stores need no clearing pass.
module permutation_gather_in_place import pgip_pkg::*; #(
    parameter int DEPTH      = DEF_DEPTH,
    parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // elem_value[31:0], source_index[37:32], zero pad
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // out_value[31:0]
    output logic                  m_tlast,
    output logic                  m_tuser   // bad_permutation[0]
);

    localparam int AW = $clog2(DEPTH);

    logic                  wr_en;
    logic [AW:0]           wr_addr;
    logic [ELEM_WIDTH-1:0] wr_value;
    logic [AW-1:0]         wr_index;
    logic                  q_full;
    logic                  push;
    set_desc_t             push_desc;
    logic                  pop;
    logic                  q_valid;
    set_desc_t             q_head;
    logic                  idx_re;
    logic [AW:0]           idx_raddr;
    logic [AW-1:0]         idx_rdata;
    logic                  val_re;
    logic [AW:0]           val_raddr;
    logic [ELEM_WIDTH-1:0] val_rdata;

    pgip_front #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .elem_value   (s_tdata[VALUE_W-1:0]),
        .source_index (s_tdata[VALUE_W+INDEX_W-1:VALUE_W]),
        .last_item    (s_tlast),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_value     (wr_value),
        .wr_index     (wr_index),
        .q_full       (q_full),
        .push         (push),
        .push_desc    (push_desc)
    );

    pgip_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    pgip_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (2 * (1 << AW))
    ) u_value_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_value),
        .re    (val_re),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    pgip_ram #(
        .WIDTH (AW),
        .DEPTH (2 * (1 << AW))
    ) u_index_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_index),
        .re    (idx_re),
        .raddr (idx_raddr),
        .rdata (idx_rdata)
    );

    pgip_back #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .pop       (pop),
        .idx_re    (idx_re),
        .idx_raddr (idx_raddr),
        .idx_rdata (idx_rdata),
        .val_re    (val_re),
        .val_raddr (val_raddr),
        .val_rdata (val_rdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

### test/tb_top.sv
// Self-checking testbench for the in-place permutation gather block with a stream-side scoreboard.
`timescale 1ns / 1ps

module tb_top;
    import pgip_pkg::*;

    localparam int DEPTH       = DEF_DEPTH;
    localparam int RANDOM_ITEMS = 270;
    localparam int DRAIN_TAIL  = 24;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {
        SET_VALID,
        SET_REPEAT,
        SET_RANGE
    } set_kind_t;

    typedef struct packed {
        logic [OUT_DATA_W-1:0] value;
        logic                  last;
        logic                  bad;
    } emit_t;

    class gather_scoreboard;
        logic [VALUE_W-1:0] values [DEPTH];
        logic [INDEX_W-1:0] sources [DEPTH];
        int unsigned        fill;
        emit_t              pending_emits [$];
        int unsigned        mismatches;

        function new();
            fill = 0;
            mismatches = 0;
        endfunction

        function void note_load(logic [VALUE_W-1:0] v, logic [INDEX_W-1:0] s, logic closes);
            bit          seen [DEPTH];
            int unsigned n;
            bit          ok;
            emit_t       e;
            values[fill] = v;
            sources[fill] = s;
            fill++;
            if (!closes && fill < DEPTH)
                return;
            n = fill;
            fill = 0;
            ok = 1'b1;
            for (int i = 0; i < DEPTH; i++)
                seen[i] = 1'b0;
            for (int i = 0; i < n; i++)
            begin
                if (sources[i] >= n || seen[sources[i]])
                    ok = 1'b0;
                else
                    seen[sources[i]] = 1'b1;
            end
            if (!ok)
            begin
                e.value = '0;
                e.last = 1'b1;
                e.bad = 1'b1;
                pending_emits.push_back(e);
            end
            else
            begin
                for (int i = 0; i < n; i++)
                begin
                    e.value = values[sources[i]];
                    e.last = (i == n - 1);
                    e.bad = 1'b0;
                    pending_emits.push_back(e);
                end
            end
        endfunction

        function void check_emit(logic [OUT_DATA_W-1:0] v, logic last, logic bad);
            emit_t e;
            if (pending_emits.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: unexpected result value=%h last=%b bad=%b", $realtime, v,
                             last, bad);
                mismatches++;
                return;
            end
            e = pending_emits.pop_front();
            if (v !== e.value || last !== e.last || bad !== e.bad)
            begin
                if (mismatches < 10)
                    $display("%0t: mismatch expected value=%h last=%b bad=%b, got value=%h last=%b bad=%b",
                             $realtime, e.value, e.last, e.bad, v, last, bad);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    gather_scoreboard   sb;
    int unsigned        cycle_count = 0;
    int unsigned        items_sent = 0;
    int                 burst_left = 0;
    int                 ready_mode = 0;
    int                 mode_left = 0;
    int unsigned        ready_phase = 0;
    logic [VALUE_W-1:0] set_val [DEPTH];
    logic [INDEX_W-1:0] set_idx [DEPTH];

    permutation_gather_in_place #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (DEF_ELEM_WIDTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL permutation_gather_in_place");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_load(s_tdata[VALUE_W-1:0], s_tdata[VALUE_W+INDEX_W-1:VALUE_W], s_tlast);
            if (m_tvalid && m_tready)
                sb.check_emit(m_tdata, m_tlast, m_tuser);
        end
    end

    // The receiver switches at random among full speed, light, heavy and periodic stalling.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            ready_phase++;
            case (ready_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 9) < 3);
                default: m_tready <= (ready_phase % 3 == 0);
            endcase
        end
    end

    task automatic send_item(logic [VALUE_W-1:0] v, logic [INDEX_W-1:0] s, logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, s, v};
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    task automatic send_set(int n, logic close_flag);
        for (int i = 0; i < n; i++)
            send_item(set_val[i], set_idx[i], (i == n - 1) ? close_flag : 1'b0);
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending_emits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    task automatic build_random_set(int n, set_kind_t kind);
        int j;
        int k;
        logic [INDEX_W-1:0] t;
        for (int i = 0; i < n; i++)
        begin
            set_idx[i] = INDEX_W'(i);
            case ($urandom_range(0, 9))
                0: set_val[i] = '0;
                1: set_val[i] = '1;
                default: set_val[i] = $urandom;
            endcase
        end
        for (int i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = set_idx[i];
            set_idx[i] = set_idx[j];
            set_idx[j] = t;
        end
        if (kind == SET_REPEAT)
        begin
            j = $urandom_range(0, n - 1);
            k = $urandom_range(0, n - 2);
            if (k >= j)
                k++;
            set_idx[j] = set_idx[k];
        end
        else if (kind == SET_RANGE)
            set_idx[$urandom_range(0, n - 1)] = INDEX_W'($urandom_range(n, DEPTH - 1));
    endtask

    initial
    begin
        int          n;
        int          pick;
        int unsigned target;
        int unsigned halfway;
        int unsigned set_count;
        bit          drained_mid;
        set_kind_t   kind;

        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-element sets, one valid and one pointing past the end.
        send_item('1, 6'd0, 1'b1);
        send_item('0, 6'd63, 1'b1);
        // A swap of the extreme values and a repeated index.
        set_val[0] = '0;
        set_val[1] = '1;
        set_idx[0] = 6'd1;
        set_idx[1] = 6'd0;
        send_set(2, 1'b1);
        set_idx[0] = 6'd0;
        set_idx[1] = 6'd0;
        send_set(2, 1'b1);
        // Identity, a single long cycle, an index of 63 in a short set, two short cycles.
        for (int i = 0; i < 5; i++)
        begin
            set_val[i] = 32'hA5A5_0000 + i;
            set_idx[i] = INDEX_W'(i);
        end
        send_set(4, 1'b1);
        for (int i = 0; i < 5; i++)
            set_idx[i] = INDEX_W'((i + 1) % 5);
        send_set(5, 1'b1);
        set_idx[0] = 6'd1;
        set_idx[1] = 6'd0;
        set_idx[2] = 6'd63;
        send_set(3, 1'b1);
        set_idx[0] = 6'd1;
        set_idx[1] = 6'd0;
        set_idx[2] = 6'd3;
        set_idx[3] = 6'd2;
        send_set(4, 1'b1);

        wait_for_drain();

        target = items_sent + RANDOM_ITEMS;
        halfway = items_sent + RANDOM_ITEMS / 2;
        set_count = 0;
        drained_mid = 1'b0;
        while (items_sent < target)
        begin
            set_count++;
            pick = $urandom_range(0, 99);
            if (set_count == 5 || set_count == 20 || pick < 2)
                n = DEPTH;
            else if (pick < 14)
                n = $urandom_range(9, 20);
            else
                n = $urandom_range(1, 8);
            pick = $urandom_range(0, 99);
            if (pick < 75)
                kind = SET_VALID;
            else if (pick < 87)
                kind = SET_REPEAT;
            else
                kind = SET_RANGE;
            if (kind == SET_RANGE && n == DEPTH)
                kind = SET_REPEAT;
            if (kind == SET_REPEAT && n == 1)
                kind = SET_RANGE;
            build_random_set(n, kind);
            send_set(n, (n == DEPTH) ? logic'($urandom_range(0, 1)) : 1'b1);
            if (!drained_mid && items_sent >= halfway)
            begin
                wait_for_drain();
                drained_mid = 1'b1;
            end
        end

        wait_for_drain();
        if (sb.mismatches == 0 && sb.pending_emits.size() == 0)
            $display("PASS permutation_gather_in_place");
        else
            $display("FAIL permutation_gather_in_place");
        $finish;
    end

endmodule

### sim.f
design/pgip_pkg.sv
design/pgip_ram.sv
design/pgip_front.sv
design/pgip_queue.sv
design/pgip_back.sv
design/permutation_gather_in_place.sv
test/tb_top.sv
